@@ hw/rtl/plvp_pkg.sv @@
`timescale 1ns / 1ps
package plvp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_TIME = 2'd0,
        CFG_PARENT_X   = 2'd1,
        CFG_PARENT_Y   = 2'd2,
        CFG_PARENT_Z   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic               alive_in;
        logic        [30:0] life_total;
        logic signed [31:0] life_left_in;
        logic signed [31:0] start_vel_x;
        logic signed [31:0] start_vel_y;
        logic signed [31:0] start_vel_z;
        logic signed [31:0] end_vel_x;
        logic signed [31:0] end_vel_y;
        logic signed [31:0] end_vel_z;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] pos_z_in;
    } t_in;

    typedef struct packed {
        logic               alive_out;
        logic               died;
        logic signed [31:0] life_left_out;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] pos_z_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic signed [31:0] vel_z_out;
    } t_out;

    // record travelling alongside the divider
    typedef struct packed {
        logic               alive;
        logic               died;
        logic               tot_zero;
        logic signed [31:0] left;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_rec;

    // record travelling alongside the lanes
    typedef struct packed {
        logic               alive;
        logic               died;
        logic signed [31:0] left;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_meta;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sh7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -66'sh8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/plvp_div.sv @@
`timescale 1ns / 1ps
module plvp_div #(
    parameter int DW = 48,
    parameter int NW = 31,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [DW-1:0] i_dvd,
    input  logic [NW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic [DW-1:0] r_dq   [DW];
    logic [NW-1:0] r_rem  [DW];
    logic [NW-1:0] r_den  [DW];
    logic [SW-1:0] r_side [DW];
    logic [DW-1:0] r_vld;

    logic [DW-1:0] w_dq   [DW+1];
    logic [NW-1:0] w_rem  [DW+1];
    logic [NW-1:0] w_den  [DW+1];
    logic [SW-1:0] w_side [DW+1];
    logic [DW:0]   w_vld;

    assign w_dq[0]   = i_dvd;
    assign w_rem[0]  = '0;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;
    assign w_vld[0]  = i_vld;

    // one quotient bit per stage
    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [NW:0]   t;
        logic [NW:0]   d;
        logic          ge;
        logic [NW-1:0] n_rem;
        logic [DW-1:0] n_dq;

        always_comb begin
            t     = {w_rem[k], w_dq[k][DW-1]};
            d     = t - {1'b0, w_den[k]};
            ge    = (t >= {1'b0, w_den[k]});
            n_rem = ge ? d[NW-1:0] : t[NW-1:0];
            n_dq  = {w_dq[k][DW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[k]   <= n_dq;
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den[k];
                r_side[k] <= w_side[k];
            end
        end

        assign w_dq[k+1]   = r_dq[k];
        assign w_rem[k+1]  = r_rem[k];
        assign w_den[k+1]  = r_den[k];
        assign w_side[k+1] = r_side[k];
        assign w_vld[k+1]  = r_vld[k];
    end

    assign o_vld  = w_vld[DW];
    assign o_quo  = w_dq[DW];
    assign o_side = w_side[DW];

endmodule

@@ hw/rtl/plvp_lane.sv @@
`timescale 1ns / 1ps
module plvp_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_start,
    input  logic signed [31:0] i_end,
    input  logic signed [31:0] i_ratio,
    input  logic signed [31:0] i_parent,
    input  logic        [30:0] i_dt,
    input  logic signed [31:0] i_pos,
    output logic signed [31:0] o_vel,
    output logic signed [31:0] o_pos
);
    import plvp_pkg::*;

    logic signed [32:0] diff;
    logic signed [64:0] r_prod;
    logic signed [31:0] r_start;
    logic signed [31:0] r_pos_a;
    logic signed [65:0] vsum;
    logic signed [31:0] r_vel_b;
    logic signed [31:0] r_pos_b;
    logic signed [63:0] r_mv;
    logic signed [31:0] r_vel_c;
    logic signed [31:0] r_pos_c;
    logic signed [65:0] psum;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_pos;

    assign diff = 33'(i_end) - 33'(i_start);
    assign vsum = 66'(r_start) + 66'(r_prod >>> FRAC_BITS) + 66'(i_parent);
    assign psum = 66'(r_pos_c) + 66'(r_mv >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= 65'(diff) * 65'(i_ratio);
            r_start <= i_start;
            r_pos_a <= i_pos;
            r_vel_b <= sat32(vsum);
            r_pos_b <= r_pos_a;
            r_mv    <= 64'(r_vel_b) * 64'($signed({1'b0, i_dt}));
            r_vel_c <= r_vel_b;
            r_pos_c <= r_pos_b;
            r_vel   <= r_vel_c;
            r_pos   <= sat32(psum);
        end
    end

    assign o_vel = r_vel;
    assign o_pos = r_pos;

endmodule

@@ hw/rtl/particle_life_velocity_position_update.sv @@
`timescale 1ns / 1ps
// Advances one particle record by one frame per beat.
// Input channel: i_in_valid / o_in_ready with the record on i_in_data.
// Output channel: o_out_valid / i_out_ready with the result on o_out_data.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
// (0 frame time, 1..3 parent velocity x/y/z); write only while idle.
// A restoring divider with one quotient bit per stage over FRAC_BITS + 32
// stages forms the age ratio; then come the ratio register, the three axis
// lanes (multiply, add, multiply, add) and one output register.
// Throughput is one beat per cycle. The whole pipeline advances together,
// so a new record is taken in every cycle in which the output register is
// empty or being emptied. While the receiver holds i_out_ready low with a
// result shown, o_in_ready is low and everything holds in place.
// Reset empties the pipeline and loads frame time 1092 and zero parent
// velocity.
module particle_life_velocity_position_update #(
    parameter int FRAC_BITS = plvp_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [plvp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [plvp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  plvp_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output plvp_pkg::t_out                      o_out_data
);
    import plvp_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int SW = $bits(t_rec);
    localparam int NL = 4;
    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] Q_LIM = (DW'(1) << 31) + ONE_Q;
    localparam logic signed [65:0] DEAD_Y = -(66'sd1000 <<< FRAC_BITS);

    logic        [30:0] r_dt;
    logic signed [31:0] r_par_x;
    logic signed [31:0] r_par_y;
    logic signed [31:0] r_par_z;

    logic en;
    logic signed [32:0] left33;
    logic [DW-1:0] dvd;
    t_rec in_rec;
    logic div_vld;
    logic [DW-1:0] div_quo;
    logic [SW-1:0] div_side;
    t_rec div_rec;

    logic r_rat_vld;
    logic signed [31:0] r_ratio;
    logic signed [31:0] n_ratio;
    t_rec r_rrec;

    logic [NL-1:0] r_ln_vld;
    t_meta r_meta [NL];

    logic signed [31:0] vel_x, vel_y, vel_z;
    logic signed [31:0] pos_x, pos_y, pos_z;

    logic r_out_vld;
    t_out r_out;
    t_out n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= 31'd1092;
            r_par_x <= '0;
            r_par_y <= '0;
            r_par_z <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_TIME: r_dt    <= i_cfg_data[30:0];
                CFG_PARENT_X:   r_par_x <= i_cfg_data;
                CFG_PARENT_Y:   r_par_y <= i_cfg_data;
                CFG_PARENT_Z:   r_par_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !r_out_vld || i_out_ready;
    assign o_in_ready = en;

    // remaining life and divider operands
    always_comb begin
        left33           = 33'(i_in_data.life_left_in) - 33'($signed({2'b00, r_dt}));
        dvd              = (DW'(left33[30:0]) << FRAC_BITS) + DW'(i_in_data.life_total)
                           - DW'(1);
        in_rec.alive     = i_in_data.alive_in;
        in_rec.died      = i_in_data.alive_in && left33[32];
        in_rec.tot_zero  = (i_in_data.life_total == '0);
        if (!i_in_data.alive_in) begin
            in_rec.left = i_in_data.life_left_in;
        end else begin
            in_rec.left = sat32(66'(left33));
        end
        in_rec.start_x   = i_in_data.start_vel_x;
        in_rec.start_y   = i_in_data.start_vel_y;
        in_rec.start_z   = i_in_data.start_vel_z;
        in_rec.end_x     = i_in_data.end_vel_x;
        in_rec.end_y     = i_in_data.end_vel_y;
        in_rec.end_z     = i_in_data.end_vel_z;
        in_rec.pos_x     = i_in_data.pos_x_in;
        in_rec.pos_y     = i_in_data.pos_y_in;
        in_rec.pos_z     = i_in_data.pos_z_in;
    end

    plvp_div #(
        .DW (DW),
        .NW (31),
        .SW (SW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (i_in_valid),
        .i_dvd  (dvd),
        .i_den  (i_in_data.life_total),
        .i_side (in_rec),
        .o_vld  (div_vld),
        .o_quo  (div_quo),
        .o_side (div_side)
    );

    assign div_rec = t_rec'(div_side);

    // ratio = one minus ceil(left / total), saturated low; one when total is zero
    always_comb begin
        if (div_rec.tot_zero) begin
            n_ratio = 32'(ONE_Q);
        end else if (div_quo > Q_LIM) begin
            n_ratio = 32'sh8000_0000;
        end else begin
            n_ratio = 32'(ONE_Q - div_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rat_vld <= 1'b0;
            r_ln_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_rat_vld <= div_vld;
            r_ln_vld  <= {r_ln_vld[NL-2:0], r_rat_vld};
            r_out_vld <= r_ln_vld[NL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ratio        <= n_ratio;
            r_rrec         <= div_rec;
            r_meta[0]      <= '{alive: r_rrec.alive, died: r_rrec.died, left: r_rrec.left,
                                pos_x: r_rrec.pos_x, pos_y: r_rrec.pos_y,
                                pos_z: r_rrec.pos_z};
            for (int i = 1; i < NL; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
            r_out          <= n_out;
        end
    end

    plvp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_start(r_rrec.start_x), .i_end(r_rrec.end_x),
        .i_ratio(r_ratio), .i_parent(r_par_x), .i_dt(r_dt), .i_pos(r_rrec.pos_x),
        .o_vel(vel_x), .o_pos(pos_x)
    );

    plvp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_start(r_rrec.start_y), .i_end(r_rrec.end_y),
        .i_ratio(r_ratio), .i_parent(r_par_y), .i_dt(r_dt), .i_pos(r_rrec.pos_y),
        .o_vel(vel_y), .o_pos(pos_y)
    );

    plvp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .i_clk(i_clk), .i_en(en), .i_start(r_rrec.start_z), .i_end(r_rrec.end_z),
        .i_ratio(r_ratio), .i_parent(r_par_z), .i_dt(r_dt), .i_pos(r_rrec.pos_z),
        .o_vel(vel_z), .o_pos(pos_z)
    );

    // merge lanes with the record's fate
    always_comb begin
        n_out.alive_out     = 1'b0;
        n_out.died          = 1'b0;
        n_out.life_left_out = r_meta[NL-1].left;
        n_out.pos_x_out     = r_meta[NL-1].pos_x;
        n_out.pos_y_out     = r_meta[NL-1].pos_y;
        n_out.pos_z_out     = r_meta[NL-1].pos_z;
        n_out.vel_x_out     = '0;
        n_out.vel_y_out     = '0;
        n_out.vel_z_out     = '0;
        if (r_meta[NL-1].alive) begin
            if (r_meta[NL-1].died) begin
                n_out.died      = 1'b1;
                n_out.pos_y_out = sat32(DEAD_Y);
            end else begin
                n_out.alive_out = 1'b1;
                n_out.pos_x_out = pos_x;
                n_out.pos_y_out = pos_y;
                n_out.pos_z_out = pos_z;
                n_out.vel_x_out = vel_x;
                n_out.vel_y_out = vel_y;
                n_out.vel_z_out = vel_z;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/plvp_checker.sv @@
`timescale 1ns / 1ps
module plvp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input plvp_pkg::t_out o_out_data
);
    import plvp_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled beat changed");

    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_died_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.died |-> !o_out_data.alive_out)
        else $error("dead particle still active");

    a_died_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.alive_out |->
            o_out_data.vel_x_out == '0 && o_out_data.vel_y_out == '0 &&
            o_out_data.vel_z_out == '0)
        else $error("velocity on inactive particle");

endmodule

bind particle_life_velocity_position_update plvp_checker u_plvp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

@@ verif/particle_life_velocity_position_update_checker.sv @@
`timescale 1ns / 1ps
module particle_life_velocity_position_update_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [plvp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [plvp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  plvp_pkg::t_in                     i_in_data,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  plvp_pkg::t_out                    i_out_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_deaths
);
    import plvp_pkg::*;

    logic        [30:0] frame_dt;
    logic signed [31:0] parent_x;
    logic signed [31:0] parent_y;
    logic signed [31:0] parent_z;
    t_out               frames_due[$];

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -128'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] lane_velocity(input logic signed [31:0] s,
            input logic signed [31:0] e, input logic signed [127:0] ratio,
            input logic signed [31:0] parent);
        logic signed [127:0] s_w;
        logic signed [127:0] e_w;
        logic signed [127:0] p_w;
        s_w = s;
        e_w = e;
        p_w = parent;
        return clamp32(s_w + (((e_w - s_w) * ratio) >>> 16) + p_w);
    endfunction

    function automatic logic signed [31:0] moved_pos(input logic signed [31:0] p,
            input logic signed [31:0] v, input logic signed [127:0] dt);
        logic signed [127:0] p_w;
        logic signed [127:0] v_w;
        p_w = p;
        v_w = v;
        return clamp32(p_w + ((v_w * dt) >>> 16));
    endfunction

    function automatic t_out advance_particle(input t_in p);
        t_out                r;
        logic signed [127:0] dt;
        logic signed [127:0] left;
        logic signed [127:0] total;
        logic signed [127:0] num;
        logic signed [127:0] ratio;
        logic signed [127:0] left_in;
        dt      = signed'({97'b0, frame_dt});
        total   = signed'({97'b0, p.life_total});
        left_in = p.life_left_in;
        r       = '0;
        if (!p.alive_in) begin
            r.life_left_out = p.life_left_in;
            r.pos_x_out     = p.pos_x_in;
            r.pos_y_out     = p.pos_y_in;
            r.pos_z_out     = p.pos_z_in;
            return r;
        end
        left = left_in - dt;
        if (left < 0) begin
            r.died          = 1'b1;
            r.life_left_out = clamp32(left);
            r.pos_x_out     = p.pos_x_in;
            r.pos_y_out     = clamp32(-128'sd1000 * 128'sd65536);
            r.pos_z_out     = p.pos_z_in;
            return r;
        end
        if (total == 0) begin
            ratio = 128'sd65536;
        end else begin
            num   = (total - left) * 128'sd65536;
            ratio = num / total;
            if ((num % total) != 0 && num < 0) begin
                ratio = ratio - 1;
            end
            ratio = clamp32(ratio);
        end
        r.alive_out     = 1'b1;
        r.life_left_out = left[31:0];
        r.vel_x_out     = lane_velocity(p.start_vel_x, p.end_vel_x, ratio, parent_x);
        r.vel_y_out     = lane_velocity(p.start_vel_y, p.end_vel_y, ratio, parent_y);
        r.vel_z_out     = lane_velocity(p.start_vel_z, p.end_vel_z, ratio, parent_z);
        r.pos_x_out     = moved_pos(p.pos_x_in, r.vel_x_out, dt);
        r.pos_y_out     = moved_pos(p.pos_y_in, r.vel_y_out, dt);
        r.pos_z_out     = moved_pos(p.pos_z_in, r.vel_z_out, dt);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out due;
        if (!i_rst_n) begin
            frame_dt     <= 31'd1092;
            parent_x     <= '0;
            parent_y     <= '0;
            parent_z     <= '0;
            o_fail_count = 0;
            o_pending    = 0;
            o_deaths     = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_TIME: frame_dt <= i_cfg_data[30:0];
                    CFG_PARENT_X:   parent_x <= i_cfg_data;
                    CFG_PARENT_Y:   parent_y <= i_cfg_data;
                    CFG_PARENT_Z:   parent_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    due = frames_due.pop_front();
                    if (due !== i_out_data) begin
                        $display("%0t: mismatch, expected %h, actual %h",
                                 $time, due, i_out_data);
                        o_fail_count++;
                    end
                    if (due.died) begin
                        o_deaths++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                frames_due.push_back(advance_particle(i_in_data));
            end
            o_pending = frames_due.size();
        end
    end
endmodule

@@ verif/particle_life_velocity_position_update_test.sv @@
`timescale 1ns / 1ps
module particle_life_velocity_position_update_test;
    import plvp_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out                  o_out_data;
    int                    fail_count;
    int                    pending;
    int                    deaths;
    int                    sent;
    int                    phases;
    bit                    no_gaps;
    logic [30:0]           cur_dt;

    particle_life_velocity_position_update DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    particle_life_velocity_position_update_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_deaths(deaths)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("particle_life_velocity_position_update_test NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45) begin
            return 0;
        end else if (r < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    task automatic send_particle(input t_in p);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_FRAME_TIME) begin
            cur_dt = data[30:0];
        end
    endtask

    task automatic write_all(input logic [31:0] dt, input logic [31:0] px,
                             input logic [31:0] py, input logic [31:0] pz);
        write_reg(CFG_FRAME_TIME, dt);
        write_reg(CFG_PARENT_X, px);
        write_reg(CFG_PARENT_Y, py);
        write_reg(CFG_PARENT_Z, pz);
        i_cfg_we <= 1'b0;
        phases++;
    endtask

    function automatic logic [31:0] rand_vel();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    function automatic t_in make_particle();
        t_in          p;
        int           kind;
        logic [63:0]  lim;
        logic [383:0] raw;
        p.alive_in     = 1'b1;
        p.life_total   = ($urandom_range(0, 15) == 0) ? 31'd0 :
                         (($urandom_range(0, 3) == 0) ? 31'($urandom) :
                          31'($urandom_range(1, 32'h0008_0000)));
        p.start_vel_x  = rand_vel();
        p.start_vel_y  = rand_vel();
        p.start_vel_z  = rand_vel();
        p.end_vel_x    = rand_vel();
        p.end_vel_y    = rand_vel();
        p.end_vel_z    = rand_vel();
        p.pos_x_in     = rand_vel();
        p.pos_y_in     = rand_vel();
        p.pos_z_in     = rand_vel();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            p = raw[$bits(t_in)-1:0];
        end else if (kind == 1) begin
            if (cur_dt != 0 && $urandom_range(0, 1) == 0) begin
                p.life_left_in = 32'($urandom_range(0, 32'(cur_dt) - 1));
            end else begin
                p.life_left_in = $urandom | 32'h8000_0000;
            end
        end else begin
            lim = 64'(cur_dt) + 64'($urandom_range(0, 32'(p.life_total) + 1000));
            p.life_left_in = (lim > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : lim[31:0];
        end
        return p;
    endfunction

    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_out_ready <= 1'b0;
                repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(1, 4))
                    @(posedge i_clk);
            end
        end
    end

    initial begin
        t_in p;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        sent       = 0;
        phases     = 0;
        no_gaps    = 1'b0;
        cur_dt     = 31'd1092;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // inactive, all ones and all zeros
        p = '1; p.alive_in = 1'b0; send_particle(p);
        p = '0; send_particle(p);
        // death just before the frame, and at the most negative life
        p = '0; p.alive_in = 1'b1; p.life_total = 31'd5000; p.life_left_in = 32'd1091;
        send_particle(p);
        p.life_left_in = 32'h8000_0000; send_particle(p);
        // left exactly zero, zero total, left above total
        p.life_left_in = 32'd1092; p.end_vel_x = 32'h0001_0000; send_particle(p);
        p.life_total = '0; p.end_vel_y = 32'hFFFF_0000; send_particle(p);
        p.life_total = 31'd10; p.life_left_in = 32'h7FFF_FFFF;
        p.start_vel_z = 32'h7FFF_FFFF; p.end_vel_z = 32'h8000_0000; send_particle(p);
        // widest velocity swing and saturating positions
        p = '1; p.alive_in = 1'b1; p.life_total = '1; p.life_left_in = 32'h4000_0000;
        p.start_vel_x = 32'h8000_0000; p.end_vel_x = 32'h7FFF_FFFF;
        p.pos_x_in = 32'h7FFF_FFFF; p.pos_y_in = 32'h8000_0000; send_particle(p);
        drain();

        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        p.life_left_in = 32'h7FFF_FFFF; p.pos_z_in = 32'h7FFF_FFFF; send_particle(p);
        p.start_vel_x = 32'h7FFF_FFFF; p.end_vel_x = 32'h8000_0000;
        p.life_total = '0; send_particle(p);
        p.life_left_in = 32'h7FFF_FFFE; send_particle(p);
        drain();
        write_all(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        p.life_left_in = 32'd0; send_particle(p);
        p.life_left_in = 32'hFFFF_FFFF; send_particle(p);
        p.life_total = 31'd1; p.life_left_in = 32'd0; send_particle(p);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(32'd1092, 32'd0, 32'd0, 32'd0);
                1: write_all(32'h7FFF_FFFF, $urandom, $urandom, $urandom);
                2: write_all(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
                3: write_all(32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
                default: write_all(32'($urandom_range(0, 32'h0004_0000)),
                                   rand_vel(), rand_vel(), rand_vel());
            endcase
            no_gaps = (ph % 3 == 2);
            for (int n = 0; n < 135; n++) begin
                send_particle(make_particle());
            end
            drain();
        end

        $display("%0d particle records over %0d register settings, %0d deaths",
                 sent, phases, deaths);
        $display("covered idle, dying and live records with saturating extremes");
        if (fail_count == 0) begin
            $display("particle_life_velocity_position_update_test OK");
        end else begin
            $display("particle_life_velocity_position_update_test NOT OK");
        end
        $finish;
    end
endmodule
